>>> hw/rtl/mflg_pkg.sv
// ----------------------------------------------------------------------------
// mflg_pkg
// Shared types and constants of the level-graph maximum flow block.
// ----------------------------------------------------------------------------
package mflg_pkg;

    localparam int NUM_VTX   = 256;
    localparam int VTX_W     = 8;
    localparam int NUM_EDGES = 2048;
    localparam int EDGE_W    = 11;
    localparam int LINK_W    = 12;
    localparam int MAX_PAIRS = 1024;
    localparam int CNT_W     = 11;
    localparam int CAP_W     = 31;
    localparam int DEPTH_W   = 9;
    localparam int VCNT_W    = 9;
    localparam int STATUS_W  = 2;

    localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(NUM_VTX);
    localparam logic [CAP_W-1:0]  FLOW_LIMIT = {CAP_W{1'b1}};
    // links carry one extra bit; set means end of list
    localparam logic [LINK_W-1:0] LINK_NULL  = {1'b1, {EDGE_W{1'b0}}};

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_VTX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAME    = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_A1, S_A2, S_A3, S_A4,
        S_W0, S_W_POP, S_W_VTX, S_W_FIRST, S_W_ERD, S_W_EDGE,
        S_PHASE, S_D_VTX, S_D_ARC, S_D_ERD, S_D_LVL, S_D_TEST,
        S_R1, S_R2, S_R3,
        S_G0, S_G1, S_G2, S_G3, S_U1, S_U2, S_U3, S_U4,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_CHECK, OP_A1, OP_A2, OP_A3, OP_A4,
        OP_W0, OP_W_POP, OP_W_VTX, OP_W_FIRST, OP_W_ERD, OP_W_EDGE,
        OP_PHASE, OP_D_VTX, OP_D_ARC, OP_D_ERD, OP_D_LVL, OP_D_TEST,
        OP_R1, OP_R2, OP_R3,
        OP_G0, OP_G1, OP_G2, OP_G3, OP_U1, OP_U2, OP_U3, OP_U4,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic bad_vertex;
        logic store_full;
        logic same_vertex;
        logic flow_cmd;
        logic queue_empty;
        logic sink_seen;
        logic first_null;
        logic next_null;
        logic arc_null;
        logic advance;
        logic hold_null;
        logic depth_zero;
        logic at_sink;
        logic scan_done;
    } dp_status_t;

endpackage

>>> hw/rtl/max_flow_level_graph.sv
// ----------------------------------------------------------------------------
// max_flow_level_graph
// Maximum flow over a stored residual graph by level walks and blocking flow.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to transfer one command: add an edge (cmd 0)
// or compute the maximum flow from from_vertex to to_vertex (cmd 1). Exactly
// one result follows, shown on status and flow_value for the single cycle in
// which done is high; the receiver cannot stall it, so capture it then. A
// max-flow query runs as long as the graph needs: its time grows with the
// vertices queued and edges scanned in each level walk, the vertices entered,
// arcs tried and retreats in the search, and the path edges of each
// augmentation. Each store has one read and one write port. No new command
// is taken until done.
// The vertex_count register is written through cfg_we/cfg_wdata; the user
// must write it only while idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module max_flow_level_graph (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic                                cfg_we,
    input  logic [mflg_pkg::VCNT_W-1:0]         cfg_wdata,
    input  logic                                cmd,
    input  logic [mflg_pkg::VTX_W-1:0]          from_vertex,
    input  logic [mflg_pkg::VTX_W-1:0]          to_vertex,
    input  logic [mflg_pkg::CAP_W-1:0]          capacity,
    output logic [mflg_pkg::STATUS_W-1:0]       status,
    output logic [mflg_pkg::CAP_W-1:0]          flow_value
);

    mflg_pkg::dp_cmd_t    dp_cmd;
    mflg_pkg::dp_status_t dp_st;
    logic                 accept;

    assign accept = start && !busy;

    mflg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .st    (dp_st),
        .cmd_o (dp_cmd),
        .busy  (busy),
        .done  (done)
    );

    mflg_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .from_vertex (from_vertex),
        .to_vertex   (to_vertex),
        .capacity    (capacity),
        .cmd_i       (dp_cmd),
        .st          (dp_st),
        .status      (status),
        .flow_value  (flow_value)
    );

endmodule

>>> hw/rtl/mflg_ctrl.sv
// ----------------------------------------------------------------------------
// mflg_ctrl
// Sequencer: steps the datapath through edge insert, level walk, depth-first
// search and augmentation.
// ----------------------------------------------------------------------------
module mflg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mflg_pkg::dp_status_t st,
    output mflg_pkg::dp_cmd_t   cmd_o,
    output logic                busy,
    output logic                done
);

    mflg_pkg::state_t state_reg;
    mflg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mflg_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mflg_pkg::S_IDLE:    if (start) state_next = mflg_pkg::S_CHECK;
            mflg_pkg::S_CHECK:
            begin
                if (st.bad_vertex)
                    state_next = mflg_pkg::S_DONE;
                else if (!st.flow_cmd)
                    state_next = st.store_full ? mflg_pkg::S_DONE : mflg_pkg::S_A1;
                else
                    state_next = st.same_vertex ? mflg_pkg::S_DONE : mflg_pkg::S_W0;
            end
            mflg_pkg::S_A1:      state_next = mflg_pkg::S_A2;
            mflg_pkg::S_A2:      state_next = mflg_pkg::S_A3;
            mflg_pkg::S_A3:      state_next = mflg_pkg::S_A4;
            mflg_pkg::S_A4:      state_next = mflg_pkg::S_DONE;
            mflg_pkg::S_W0:      state_next = mflg_pkg::S_W_POP;
            mflg_pkg::S_W_POP:
            begin
                if (st.queue_empty)
                    state_next = st.sink_seen ? mflg_pkg::S_PHASE : mflg_pkg::S_DONE;
                else
                    state_next = mflg_pkg::S_W_VTX;
            end
            mflg_pkg::S_W_VTX:   state_next = mflg_pkg::S_W_FIRST;
            mflg_pkg::S_W_FIRST:
                state_next = st.first_null ? mflg_pkg::S_W_POP : mflg_pkg::S_W_ERD;
            mflg_pkg::S_W_ERD:   state_next = mflg_pkg::S_W_EDGE;
            mflg_pkg::S_W_EDGE:
                state_next = st.next_null ? mflg_pkg::S_W_POP : mflg_pkg::S_W_ERD;
            mflg_pkg::S_PHASE:   state_next = mflg_pkg::S_D_VTX;
            mflg_pkg::S_D_VTX:
                state_next = st.at_sink ? mflg_pkg::S_G0 : mflg_pkg::S_D_ARC;
            mflg_pkg::S_D_ARC:
                state_next = st.arc_null ? mflg_pkg::S_R1 : mflg_pkg::S_D_ERD;
            mflg_pkg::S_D_ERD:   state_next = mflg_pkg::S_D_LVL;
            mflg_pkg::S_D_LVL:   state_next = mflg_pkg::S_D_TEST;
            mflg_pkg::S_D_TEST:
            begin
                if (st.advance)
                    state_next = mflg_pkg::S_D_VTX;
                else
                    state_next = st.hold_null ? mflg_pkg::S_R1 : mflg_pkg::S_D_ERD;
            end
            // dead end at the source closes the phase: rebuild levels
            mflg_pkg::S_R1:
                state_next = st.depth_zero ? mflg_pkg::S_W0 : mflg_pkg::S_R2;
            mflg_pkg::S_R2:      state_next = mflg_pkg::S_R3;
            mflg_pkg::S_R3:      state_next = mflg_pkg::S_D_VTX;
            mflg_pkg::S_G0:      state_next = mflg_pkg::S_G1;
            mflg_pkg::S_G1:
                state_next = st.scan_done ? mflg_pkg::S_U1 : mflg_pkg::S_G2;
            mflg_pkg::S_G2:      state_next = mflg_pkg::S_G3;
            mflg_pkg::S_G3:      state_next = mflg_pkg::S_G1;
            mflg_pkg::S_U1:
                state_next = st.scan_done ? mflg_pkg::S_D_VTX : mflg_pkg::S_U2;
            mflg_pkg::S_U2:      state_next = mflg_pkg::S_U3;
            mflg_pkg::S_U3:      state_next = mflg_pkg::S_U4;
            mflg_pkg::S_U4:      state_next = mflg_pkg::S_U1;
            mflg_pkg::S_DONE:    state_next = mflg_pkg::S_IDLE;
            default:             state_next = mflg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = (state_reg != mflg_pkg::S_IDLE);
        done     = (state_reg == mflg_pkg::S_DONE);
        cmd_o.op = mflg_pkg::OP_IDLE;
        case (state_reg)
            mflg_pkg::S_IDLE:    cmd_o.op = mflg_pkg::OP_IDLE;
            mflg_pkg::S_CHECK:   cmd_o.op = mflg_pkg::OP_CHECK;
            mflg_pkg::S_A1:      cmd_o.op = mflg_pkg::OP_A1;
            mflg_pkg::S_A2:      cmd_o.op = mflg_pkg::OP_A2;
            mflg_pkg::S_A3:      cmd_o.op = mflg_pkg::OP_A3;
            mflg_pkg::S_A4:      cmd_o.op = mflg_pkg::OP_A4;
            mflg_pkg::S_W0:      cmd_o.op = mflg_pkg::OP_W0;
            mflg_pkg::S_W_POP:   cmd_o.op = mflg_pkg::OP_W_POP;
            mflg_pkg::S_W_VTX:   cmd_o.op = mflg_pkg::OP_W_VTX;
            mflg_pkg::S_W_FIRST: cmd_o.op = mflg_pkg::OP_W_FIRST;
            mflg_pkg::S_W_ERD:   cmd_o.op = mflg_pkg::OP_W_ERD;
            mflg_pkg::S_W_EDGE:  cmd_o.op = mflg_pkg::OP_W_EDGE;
            mflg_pkg::S_PHASE:   cmd_o.op = mflg_pkg::OP_PHASE;
            mflg_pkg::S_D_VTX:   cmd_o.op = mflg_pkg::OP_D_VTX;
            mflg_pkg::S_D_ARC:   cmd_o.op = mflg_pkg::OP_D_ARC;
            mflg_pkg::S_D_ERD:   cmd_o.op = mflg_pkg::OP_D_ERD;
            mflg_pkg::S_D_LVL:   cmd_o.op = mflg_pkg::OP_D_LVL;
            mflg_pkg::S_D_TEST:  cmd_o.op = mflg_pkg::OP_D_TEST;
            mflg_pkg::S_R1:      cmd_o.op = mflg_pkg::OP_R1;
            mflg_pkg::S_R2:      cmd_o.op = mflg_pkg::OP_R2;
            mflg_pkg::S_R3:      cmd_o.op = mflg_pkg::OP_R3;
            mflg_pkg::S_G0:      cmd_o.op = mflg_pkg::OP_G0;
            mflg_pkg::S_G1:      cmd_o.op = mflg_pkg::OP_G1;
            mflg_pkg::S_G2:      cmd_o.op = mflg_pkg::OP_G2;
            mflg_pkg::S_G3:      cmd_o.op = mflg_pkg::OP_G3;
            mflg_pkg::S_U1:      cmd_o.op = mflg_pkg::OP_U1;
            mflg_pkg::S_U2:      cmd_o.op = mflg_pkg::OP_U2;
            mflg_pkg::S_U3:      cmd_o.op = mflg_pkg::OP_U3;
            mflg_pkg::S_U4:      cmd_o.op = mflg_pkg::OP_U4;
            mflg_pkg::S_DONE:    cmd_o.op = mflg_pkg::OP_DONE;
            default:             cmd_o.op = mflg_pkg::OP_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/mflg_dp.sv
// ----------------------------------------------------------------------------
// mflg_dp
// Datapath: edge and vertex stores, walk queue, path stack and the working
// registers of the flow search. Each store has one write and one read port.
// ----------------------------------------------------------------------------
module mflg_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                cfg_we,
    input  logic [mflg_pkg::VCNT_W-1:0]         cfg_wdata,
    input  logic                                cmd,
    input  logic [mflg_pkg::VTX_W-1:0]          from_vertex,
    input  logic [mflg_pkg::VTX_W-1:0]          to_vertex,
    input  logic [mflg_pkg::CAP_W-1:0]          capacity,
    input  mflg_pkg::dp_cmd_t                   cmd_i,
    output mflg_pkg::dp_status_t                st,
    output logic [mflg_pkg::STATUS_W-1:0]       status,
    output logic [mflg_pkg::CAP_W-1:0]          flow_value
);

    localparam int VW = mflg_pkg::VTX_W;
    localparam int EW = mflg_pkg::EDGE_W;
    localparam int LW = mflg_pkg::LINK_W;
    localparam int CW = mflg_pkg::CAP_W;
    localparam int DW = mflg_pkg::DEPTH_W;
    localparam int NV = mflg_pkg::NUM_VTX;

    // ---------------- memories ----------------
    logic [VW-1:0] tgt_mem   [mflg_pkg::NUM_EDGES];
    logic [CW-1:0] res_mem   [mflg_pkg::NUM_EDGES];
    logic [LW-1:0] nxt_mem   [mflg_pkg::NUM_EDGES];
    logic [EW-1:0] first_mem [NV];
    logic [EW-1:0] last_mem  [NV];
    logic [VW-1:0] lvl_mem   [NV];
    logic [LW-1:0] arc_mem   [NV];
    logic [VW-1:0] queue_mem [NV];
    logic [EW-1:0] stk_mem   [NV];

    logic          tgt_we, res_we, nxt_we, first_we, last_we, lvl_we, arc_we, q_we, stk_we;
    logic [EW-1:0] tgt_waddr, tgt_raddr, res_waddr, res_raddr, nxt_waddr, nxt_raddr;
    logic [VW-1:0] first_waddr, first_raddr, last_waddr, last_raddr;
    logic [VW-1:0] lvl_waddr, lvl_raddr, arc_waddr, arc_raddr;
    logic [VW-1:0] q_waddr, q_raddr, stk_waddr, stk_raddr;
    logic [VW-1:0] tgt_wdata, lvl_wdata, q_wdata;
    logic [CW-1:0] res_wdata;
    logic [LW-1:0] nxt_wdata, arc_wdata;
    logic [EW-1:0] first_wdata, last_wdata, stk_wdata;

    logic [VW-1:0] tgt_q, lvl_q, queue_q;
    logic [CW-1:0] res_q;
    logic [LW-1:0] nxt_q, arc_q;
    logic [EW-1:0] first_q, last_q, stack_q;
    logic          firstv_q, arcv_q;

    always_ff @(posedge clk)
    begin
        if (tgt_we)   tgt_mem[tgt_waddr]     <= tgt_wdata;
        if (res_we)   res_mem[res_waddr]     <= res_wdata;
        if (nxt_we)   nxt_mem[nxt_waddr]     <= nxt_wdata;
        if (first_we) first_mem[first_waddr] <= first_wdata;
        if (last_we)  last_mem[last_waddr]   <= last_wdata;
        if (lvl_we)   lvl_mem[lvl_waddr]     <= lvl_wdata;
        if (arc_we)   arc_mem[arc_waddr]     <= arc_wdata;
        if (q_we)     queue_mem[q_waddr]     <= q_wdata;
        if (stk_we)   stk_mem[stk_waddr]     <= stk_wdata;
        tgt_q   <= tgt_mem[tgt_raddr];
        res_q   <= res_mem[res_raddr];
        nxt_q   <= nxt_mem[nxt_raddr];
        first_q <= first_mem[first_raddr];
        last_q  <= last_mem[last_raddr];
        lvl_q   <= lvl_mem[lvl_raddr];
        arc_q   <= arc_mem[arc_raddr];
        queue_q <= queue_mem[q_raddr];
        stack_q <= stk_mem[stk_raddr];
    end

    // ---------------- registers ----------------
    logic [NV-1:0] first_vld_reg, first_vld_next;
    logic [NV-1:0] arc_vld_reg, arc_vld_next;
    logic [NV-1:0] seen_reg, seen_next;
    logic [mflg_pkg::VCNT_W-1:0] vcount_reg, vcount_next;
    logic [mflg_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic          cmd_reg, cmd_next;
    logic [VW-1:0] a_reg, a_next, b_reg, b_next, v_reg, v_next, u_reg, u_next;
    logic [VW-1:0] lv_reg, lv_next;
    logic [CW-1:0] cap_reg, cap_next, d_reg, d_next, total_reg, total_next;
    logic [CW-1:0] hold_res_reg, hold_res_next;
    logic [LW-1:0] e_reg, e_next, arc_reg, arc_next, hold_nxt_reg, hold_nxt_next;
    logic [DW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [DW-1:0] depth_reg, depth_next, i_reg, i_next;
    logic [mflg_pkg::STATUS_W-1:0] status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_vld_reg <= '0;
            vcount_reg    <= mflg_pkg::VCNT_RESET;
            cnt_reg       <= '0;
            status_reg    <= mflg_pkg::ST_OK;
            total_reg     <= '0;
        end
        else
        begin
            first_vld_reg <= first_vld_next;
            vcount_reg    <= vcount_next;
            cnt_reg       <= cnt_next;
            status_reg    <= status_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arc_vld_reg  <= arc_vld_next;
        seen_reg     <= seen_next;
        cmd_reg      <= cmd_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        v_reg        <= v_next;
        u_reg        <= u_next;
        lv_reg       <= lv_next;
        cap_reg      <= cap_next;
        d_reg        <= d_next;
        hold_res_reg <= hold_res_next;
        e_reg        <= e_next;
        arc_reg      <= arc_next;
        hold_nxt_reg <= hold_nxt_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        depth_reg    <= depth_next;
        i_reg        <= i_next;
    end

    // ---------------- derived values ----------------
    logic [EW-1:0] fwd_edge, rev_edge;
    logic [LW-1:0] arc_sel;
    logic [CW:0]   flow_sum;
    logic [DW-1:0] depth_dec;
    logic          adv;

    assign fwd_edge  = EW'({cnt_reg, 1'b0});
    assign rev_edge  = fwd_edge | EW'(1);
    assign arc_sel   = arcv_q ? arc_q : (firstv_q ? {1'b0, first_q} : mflg_pkg::LINK_NULL);
    assign flow_sum  = {1'b0, total_reg} + {1'b0, d_reg};
    assign depth_dec = depth_reg - DW'(1);
    assign adv       = (hold_res_reg != '0) && seen_reg[u_reg] && (lvl_q > lv_reg)
                       && (depth_reg < DW'(NV));

    always_comb
    begin
        st.bad_vertex  = ({1'b0, a_reg} >= vcount_reg) || ({1'b0, b_reg} >= vcount_reg);
        st.store_full  = (cnt_reg >= mflg_pkg::CNT_W'(mflg_pkg::MAX_PAIRS));
        st.same_vertex = (a_reg == b_reg);
        st.flow_cmd    = cmd_reg;
        st.queue_empty = (head_reg == tail_reg);
        st.sink_seen   = seen_reg[b_reg];
        st.first_null  = !firstv_q;
        st.next_null   = nxt_q[LW-1];
        st.arc_null    = arc_sel[LW-1];
        st.advance     = adv;
        st.hold_null   = hold_nxt_reg[LW-1];
        st.depth_zero  = (depth_reg == '0);
        st.at_sink     = (v_reg == b_reg);
        st.scan_done   = (i_reg == depth_reg);
    end

    always_comb
    begin
        first_vld_next = first_vld_reg;
        arc_vld_next   = arc_vld_reg;
        seen_next      = seen_reg;
        vcount_next    = cfg_we ? cfg_wdata : vcount_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        v_next         = v_reg;
        u_next         = u_reg;
        lv_next        = lv_reg;
        cap_next       = cap_reg;
        d_next         = d_reg;
        total_next     = total_reg;
        hold_res_next  = hold_res_reg;
        e_next         = e_reg;
        arc_next       = arc_reg;
        hold_nxt_next  = hold_nxt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        depth_next     = depth_reg;
        i_next         = i_reg;
        status_next    = status_reg;

        tgt_we = 1'b0; res_we = 1'b0; nxt_we = 1'b0; first_we = 1'b0; last_we = 1'b0;
        lvl_we = 1'b0; arc_we = 1'b0; q_we = 1'b0; stk_we = 1'b0;
        tgt_waddr = '0; tgt_raddr = '0; tgt_wdata = '0;
        res_waddr = '0; res_raddr = '0; res_wdata = '0;
        nxt_waddr = '0; nxt_raddr = '0; nxt_wdata = '0;
        first_waddr = '0; first_raddr = '0; first_wdata = '0;
        last_waddr = '0; last_raddr = '0; last_wdata = '0;
        lvl_waddr = '0; lvl_raddr = '0; lvl_wdata = '0;
        arc_waddr = '0; arc_raddr = '0; arc_wdata = '0;
        q_waddr = '0; q_raddr = '0; q_wdata = '0;
        stk_waddr = '0; stk_raddr = '0; stk_wdata = '0;

        case (cmd_i.op)
            mflg_pkg::OP_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    a_next      = from_vertex;
                    b_next      = to_vertex;
                    cap_next    = capacity;
                    total_next  = '0;
                    status_next = mflg_pkg::ST_OK;
                end
            end
            mflg_pkg::OP_CHECK:
            begin
                if (st.bad_vertex)
                    status_next = mflg_pkg::ST_BAD_VTX;
                else if (!cmd_reg)
                    status_next = st.store_full ? mflg_pkg::ST_FULL : mflg_pkg::ST_OK;
                else
                    status_next = st.same_vertex ? mflg_pkg::ST_SAME : mflg_pkg::ST_OK;
            end
            mflg_pkg::OP_A1:
            begin
                tgt_we = 1'b1; tgt_waddr = fwd_edge; tgt_wdata = b_reg;
                res_we = 1'b1; res_waddr = fwd_edge; res_wdata = cap_reg;
                nxt_we = 1'b1; nxt_waddr = fwd_edge; nxt_wdata = mflg_pkg::LINK_NULL;
                first_raddr = a_reg;
                last_raddr  = a_reg;
            end
            mflg_pkg::OP_A2:
            begin
                if (first_vld_reg[a_reg])
                begin
                    nxt_we = 1'b1; nxt_waddr = last_q; nxt_wdata = {1'b0, fwd_edge};
                end
                else
                begin
                    first_we = 1'b1; first_waddr = a_reg; first_wdata = fwd_edge;
                    first_vld_next[a_reg] = 1'b1;
                end
                last_we = 1'b1; last_waddr = a_reg; last_wdata = fwd_edge;
            end
            mflg_pkg::OP_A3:
            begin
                tgt_we = 1'b1; tgt_waddr = rev_edge; tgt_wdata = a_reg;
                res_we = 1'b1; res_waddr = rev_edge; res_wdata = '0;
                nxt_we = 1'b1; nxt_waddr = rev_edge; nxt_wdata = mflg_pkg::LINK_NULL;
                first_raddr = b_reg;
                last_raddr  = b_reg;
            end
            mflg_pkg::OP_A4:
            begin
                if (first_vld_reg[b_reg])
                begin
                    nxt_we = 1'b1; nxt_waddr = last_q; nxt_wdata = {1'b0, rev_edge};
                end
                else
                begin
                    first_we = 1'b1; first_waddr = b_reg; first_wdata = rev_edge;
                    first_vld_next[b_reg] = 1'b1;
                end
                last_we = 1'b1; last_waddr = b_reg; last_wdata = rev_edge;
                cnt_next = cnt_reg + mflg_pkg::CNT_W'(1);
            end
            mflg_pkg::OP_W0:
            begin
                seen_next        = '0;
                seen_next[a_reg] = 1'b1;
                lvl_we = 1'b1; lvl_waddr = a_reg; lvl_wdata = '0;
                q_we   = 1'b1; q_waddr = '0; q_wdata = a_reg;
                head_next = '0;
                tail_next = DW'(1);
            end
            mflg_pkg::OP_W_POP:
            begin
                q_raddr = head_reg[VW-1:0];
                if (!st.queue_empty)
                    head_next = head_reg + DW'(1);
            end
            mflg_pkg::OP_W_VTX:
            begin
                v_next      = queue_q;
                lvl_raddr   = queue_q;
                first_raddr = queue_q;
            end
            mflg_pkg::OP_W_FIRST:
            begin
                lv_next = lvl_q;
                e_next  = firstv_q ? {1'b0, first_q} : mflg_pkg::LINK_NULL;
            end
            mflg_pkg::OP_W_ERD:
            begin
                tgt_raddr = e_reg[EW-1:0];
                res_raddr = e_reg[EW-1:0];
                nxt_raddr = e_reg[EW-1:0];
            end
            mflg_pkg::OP_W_EDGE:
            begin
                if ((res_q != '0) && !seen_reg[tgt_q])
                begin
                    seen_next[tgt_q] = 1'b1;
                    lvl_we = 1'b1; lvl_waddr = tgt_q; lvl_wdata = lv_reg + VW'(1);
                    q_we   = 1'b1; q_waddr = tail_reg[VW-1:0]; q_wdata = tgt_q;
                    tail_next = tail_reg + DW'(1);
                end
                e_next = nxt_q;
            end
            mflg_pkg::OP_PHASE:
            begin
                arc_vld_next = '0;
                v_next       = a_reg;
                depth_next   = '0;
            end
            mflg_pkg::OP_D_VTX:
            begin
                arc_raddr   = v_reg;
                first_raddr = v_reg;
                lvl_raddr   = v_reg;
            end
            mflg_pkg::OP_D_ARC:
            begin
                arc_next = arc_sel;
                lv_next  = lvl_q;
            end
            mflg_pkg::OP_D_ERD:
            begin
                tgt_raddr = arc_reg[EW-1:0];
                res_raddr = arc_reg[EW-1:0];
                nxt_raddr = arc_reg[EW-1:0];
            end
            mflg_pkg::OP_D_LVL:
            begin
                u_next        = tgt_q;
                hold_res_next = res_q;
                hold_nxt_next = nxt_q;
                lvl_raddr     = tgt_q;
            end
            mflg_pkg::OP_D_TEST:
            begin
                if (adv)
                begin
                    arc_we = 1'b1; arc_waddr = v_reg; arc_wdata = arc_reg;
                    arc_vld_next[v_reg] = 1'b1;
                    stk_we = 1'b1; stk_waddr = depth_reg[VW-1:0];
                    stk_wdata = arc_reg[EW-1:0];
                    depth_next = depth_reg + DW'(1);
                    v_next     = u_reg;
                end
                else
                begin
                    arc_next = hold_nxt_reg;
                end
            end
            mflg_pkg::OP_R1:
            begin
                // vertex exhausted: park its arc at end of list, pop one edge unless the path is empty
                arc_we = 1'b1; arc_waddr = v_reg; arc_wdata = mflg_pkg::LINK_NULL;
                arc_vld_next[v_reg] = 1'b1;
                if (!st.depth_zero)
                begin
                    stk_raddr  = depth_dec[VW-1:0];
                    depth_next = depth_dec;
                end
            end
            mflg_pkg::OP_R2:
            begin
                e_next    = {1'b0, stack_q};
                tgt_raddr = stack_q ^ EW'(1);
                nxt_raddr = stack_q;
            end
            mflg_pkg::OP_R3:
            begin
                v_next = tgt_q;
                arc_we = 1'b1; arc_waddr = tgt_q; arc_wdata = nxt_q;
                arc_vld_next[tgt_q] = 1'b1;
            end
            mflg_pkg::OP_G0:
            begin
                d_next = mflg_pkg::FLOW_LIMIT;
                i_next = '0;
            end
            mflg_pkg::OP_G1:
            begin
                if (st.scan_done)
                    i_next = '0;
                else
                    stk_raddr = i_reg[VW-1:0];
            end
            mflg_pkg::OP_G2:
            begin
                res_raddr = stack_q;
            end
            mflg_pkg::OP_G3:
            begin
                d_next = (res_q < d_reg) ? res_q : d_reg;
                i_next = i_reg + DW'(1);
            end
            mflg_pkg::OP_U1:
            begin
                if (st.scan_done)
                begin
                    total_next = flow_sum[CW] ? mflg_pkg::FLOW_LIMIT : flow_sum[CW-1:0];
                    v_next     = a_reg;
                    depth_next = '0;
                end
                else
                begin
                    stk_raddr = i_reg[VW-1:0];
                end
            end
            mflg_pkg::OP_U2:
            begin
                e_next    = {1'b0, stack_q};
                res_raddr = stack_q;
            end
            mflg_pkg::OP_U3:
            begin
                res_we = 1'b1; res_waddr = e_reg[EW-1:0]; res_wdata = res_q - d_reg;
                res_raddr = e_reg[EW-1:0] ^ EW'(1);
            end
            mflg_pkg::OP_U4:
            begin
                res_we = 1'b1; res_waddr = e_reg[EW-1:0] ^ EW'(1);
                res_wdata = res_q + d_reg;
                i_next = i_reg + DW'(1);
            end
            mflg_pkg::OP_DONE:
            begin
                status_next = status_reg;
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    // valid flags are registered alongside their memories' reads
    always_ff @(posedge clk)
    begin
        firstv_q <= first_vld_reg[first_raddr];
        arcv_q   <= arc_vld_reg[arc_raddr];
    end

    assign status     = status_reg;
    assign flow_value = total_reg;

endmodule

>>> hw/rtl/mflg_checker.sv
// ----------------------------------------------------------------------------
// mflg_checker
// Port-level checks of the command handshake and result marking.
// ----------------------------------------------------------------------------
module mflg_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [mflg_pkg::STATUS_W-1:0]       status,
    input logic [mflg_pkg::CAP_W-1:0]          flow_value
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a busy period");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("block did not release after its result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != mflg_pkg::ST_OK)) |-> (flow_value == '0))
        else $error("error result carries a nonzero flow");

endmodule

bind max_flow_level_graph mflg_checker u_mflg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .flow_value (flow_value)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the level-graph maximum flow block.
// ----------------------------------------------------------------------------
// Commands are queued by the stimulus process and presented by a driver at
// the falling edge. A monitor at the rising edge computes the expected
// status and flow for every accepted command with its own copy of the
// residual graph, and checks each done pulse against the oldest expectation.
// ----------------------------------------------------------------------------
module tb;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FLOW = 1'b1;
    localparam int   NULL_E   = mflg_pkg::NUM_EDGES;
    localparam int   STALL_LIMIT = 20000000;

    typedef struct {
        logic                       op;
        logic [mflg_pkg::VTX_W-1:0] src;
        logic [mflg_pkg::VTX_W-1:0] dst;
        logic [mflg_pkg::CAP_W-1:0] cap;
    } flow_cmd_t;

    typedef struct {
        logic [mflg_pkg::STATUS_W-1:0] st;
        logic [mflg_pkg::CAP_W-1:0]    flow;
    } flow_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          done;
    logic                          cfg_we;
    logic [mflg_pkg::VCNT_W-1:0]   cfg_wdata;
    logic                          cmd;
    logic [mflg_pkg::VTX_W-1:0]    from_vertex;
    logic [mflg_pkg::VTX_W-1:0]    to_vertex;
    logic [mflg_pkg::CAP_W-1:0]    capacity;
    logic [mflg_pkg::STATUS_W-1:0] status;
    logic [mflg_pkg::CAP_W-1:0]    flow_value;

    flow_cmd_t    pending_cmds[$];
    flow_result_t expected_results[$];
    int           send_idle_pct;
    bit           took;
    bit           failed;
    int           stall_cycles;

    // graph copy used for prediction
    logic [mflg_pkg::VTX_W-1:0] g_target[mflg_pkg::NUM_EDGES];
    logic [mflg_pkg::CAP_W-1:0] g_resid[mflg_pkg::NUM_EDGES];
    int                         g_next[mflg_pkg::NUM_EDGES];
    int                         g_first[mflg_pkg::NUM_VTX];
    int                         g_last[mflg_pkg::NUM_VTX];
    int                         g_level[mflg_pkg::NUM_VTX];
    int                         g_arc[mflg_pkg::NUM_VTX];
    int                         g_queue[mflg_pkg::NUM_VTX];
    int                         g_path[mflg_pkg::NUM_VTX];
    int                         g_pairs;
    int                         g_vcount;

    max_flow_level_graph i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .from_vertex (from_vertex),
        .to_vertex   (to_vertex),
        .capacity    (capacity),
        .status      (status),
        .flow_value  (flow_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic append_link(int v, int e);
        g_next[e] = NULL_E;
        if (g_first[v] >= mflg_pkg::NUM_EDGES)
            g_first[v] = e;
        else
            g_next[g_last[v]] = e;
        g_last[v] = e;
    endtask

    task automatic level_walk(int s);
        int head;
        int tail;
        int v;
        int e;
        int u;
        head = 0;
        tail = 0;
        for (v = 0; v < mflg_pkg::NUM_VTX; v++)
            g_level[v] = -1;
        g_level[s] = 0;
        g_queue[tail++] = s;
        while (head < tail)
        begin
            v = g_queue[head++];
            e = g_first[v];
            while (e < mflg_pkg::NUM_EDGES)
            begin
                u = g_target[e];
                if (g_resid[e] > 0 && g_level[u] < 0)
                begin
                    g_level[u] = g_level[v] + 1;
                    if (tail < mflg_pkg::NUM_VTX)
                        g_queue[tail++] = u;
                end
                e = g_next[e];
            end
        end
    endtask

    task automatic push_blocking_flow(int s, int t, inout longint total);
        int depth;
        int v;
        int i;
        int arc;
        int e;
        longint d;
        bit advanced;
        depth = 0;
        v = s;
        forever
        begin
            if (v == t)
            begin
                d = mflg_pkg::FLOW_LIMIT;
                for (i = 0; i < depth; i++)
                    if (g_resid[g_path[i]] < d)
                        d = g_resid[g_path[i]];
                for (i = 0; i < depth; i++)
                begin
                    e = g_path[i];
                    g_resid[e] = g_resid[e] - mflg_pkg::CAP_W'(d);
                    g_resid[e ^ 1] = g_resid[e ^ 1] + mflg_pkg::CAP_W'(d);
                end
                total = total + d;
                if (total > mflg_pkg::FLOW_LIMIT)
                    total = mflg_pkg::FLOW_LIMIT;
                depth = 0;
                v = s;
            end
            else
            begin
                advanced = 1'b0;
                arc = g_arc[v];
                while (arc < mflg_pkg::NUM_EDGES && !advanced)
                begin
                    if (g_resid[arc] > 0 && g_level[v] < g_level[g_target[arc]]
                        && depth < mflg_pkg::NUM_VTX)
                        advanced = 1'b1;
                    else
                        arc = g_next[arc];
                end
                g_arc[v] = arc;
                if (advanced)
                begin
                    g_path[depth++] = arc;
                    v = g_target[arc];
                end
                else
                begin
                    if (depth == 0)
                        return;
                    e = g_path[--depth];
                    v = g_target[e ^ 1];
                    g_arc[v] = g_next[e];
                end
            end
        end
    endtask

    task automatic predict_flow_result(flow_cmd_t c, output flow_result_t r);
        int limit;
        int f;
        int v;
        longint total;
        limit = (g_vcount < mflg_pkg::NUM_VTX) ? g_vcount : mflg_pkg::NUM_VTX;
        total = 0;
        r.st = mflg_pkg::ST_OK;
        if (c.src >= limit || c.dst >= limit)
            r.st = mflg_pkg::ST_BAD_VTX;
        else if (c.op == CMD_ADD)
        begin
            if (g_pairs >= mflg_pkg::MAX_PAIRS)
                r.st = mflg_pkg::ST_FULL;
            else
            begin
                f = 2 * g_pairs;
                g_target[f] = c.dst;
                g_resid[f] = c.cap;
                append_link(c.src, f);
                g_target[f + 1] = c.src;
                g_resid[f + 1] = '0;
                append_link(c.dst, f + 1);
                g_pairs++;
            end
        end
        else if (c.src == c.dst)
            r.st = mflg_pkg::ST_SAME;
        else
        begin
            forever
            begin
                level_walk(c.src);
                if (g_level[c.dst] < 0)
                    break;
                for (v = 0; v < mflg_pkg::NUM_VTX; v++)
                    g_arc[v] = g_first[v];
                push_blocking_flow(c.src, c.dst, total);
            end
        end
        r.flow = total[mflg_pkg::CAP_W-1:0];
    endtask

    initial
    begin
        g_pairs = 0;
        g_vcount = mflg_pkg::NUM_VTX;
        for (int v = 0; v < mflg_pkg::NUM_VTX; v++)
            g_first[v] = NULL_E;
    end

    // monitor: check results, then predict newly accepted commands
    always @(posedge clk)
    begin
        flow_result_t want;
        flow_cmd_t    c;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none pending: status %0d flow %0d",
                             $time, status, flow_value);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                        failed = 1'b1;
                    end
                    if (flow_value !== want.flow)
                    begin
                        $display("%0t: flow_value expected %0d actual %0d",
                                 $time, want.flow, flow_value);
                        failed = 1'b1;
                    end
                end
            end
            took = start && !busy;
            if (took)
            begin
                c.op = cmd;
                c.src = from_vertex;
                c.dst = to_vertex;
                c.cap = capacity;
                predict_flow_result(c, want);
                expected_results.push_back(want);
            end
            if (cfg_we)
                g_vcount = cfg_wdata;
            if (took || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // driver: hold start until the transfer happens, then advance
    always @(negedge clk)
    begin
        flow_cmd_t c;
        if (rst_n && (!start || took))
        begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                c = pending_cmds.pop_front();
                start <= 1'b1;
                cmd <= c.op;
                from_vertex <= c.src;
                to_vertex <= c.dst;
                capacity <= c.cap;
            end
            else
                start <= 1'b0;
        end
    end

    task automatic queue_cmd(logic op, int a, int b, logic [mflg_pkg::CAP_W-1:0] cap);
        flow_cmd_t c;
        c.op = op;
        c.src = a[mflg_pkg::VTX_W-1:0];
        c.dst = b[mflg_pkg::VTX_W-1:0];
        c.cap = cap;
        pending_cmds.push_back(c);
    endtask

    // let the driver's updates settle before looking at start
    task automatic drain();
        while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
        begin
            @(negedge clk);
            #1;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_vcount(int v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v[mflg_pkg::VCNT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [mflg_pkg::CAP_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 60)
            return mflg_pkg::CAP_W'($urandom_range(20, 1));
        if (r < 70)
            return mflg_pkg::FLOW_LIMIT;
        return mflg_pkg::CAP_W'($urandom());
    endfunction

    // mostly in-range commands over a small vertex span; some noise
    task automatic queue_random(int count, int span);
        int r;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 6)
                queue_cmd(logic'($urandom_range(1)), $urandom_range(255),
                          $urandom_range(255), mflg_pkg::CAP_W'($urandom()));
            else if (r < 18)
                queue_cmd(CMD_FLOW, $urandom_range(span - 1),
                          $urandom_range(span - 1), mflg_pkg::CAP_W'($urandom()));
            else
                queue_cmd(CMD_ADD, $urandom_range(span - 1),
                          $urandom_range(span - 1), pick_capacity());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cmd = CMD_ADD;
        from_vertex = '0;
        to_vertex = '0;
        capacity = '0;
        took = 1'b0;
        failed = 1'b0;
        stall_cycles = 0;
        send_idle_pct = 32;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // parallel maximum edges saturate the total; reverse query reuses them
        queue_cmd(CMD_ADD, 0, 255, mflg_pkg::FLOW_LIMIT);
        queue_cmd(CMD_ADD, 0, 255, mflg_pkg::FLOW_LIMIT);
        queue_cmd(CMD_FLOW, 0, 255, '0);
        queue_cmd(CMD_FLOW, 255, 0, mflg_pkg::FLOW_LIMIT);
        queue_cmd(CMD_ADD, 5, 5, 7);
        queue_cmd(CMD_ADD, 5, 6, 3);
        queue_cmd(CMD_ADD, 6, 7, 4);
        queue_cmd(CMD_ADD, 3, 3, 0);
        queue_cmd(CMD_FLOW, 5, 7, 0);
        queue_cmd(CMD_FLOW, 7, 5, 0);
        queue_cmd(CMD_FLOW, 4, 4, 0);
        write_vcount(8);
        queue_cmd(CMD_ADD, 200, 1, 5);
        queue_cmd(CMD_FLOW, 1, 9, 0);
        queue_cmd(CMD_ADD, 5, 255, 5);
        queue_cmd(CMD_FLOW, 9, 9, 0);
        queue_cmd(CMD_FLOW, 0, 7, 0);
        queue_cmd(CMD_FLOW, 5, 7, 0);
        write_vcount(2);
        queue_cmd(CMD_ADD, 0, 1, 1);
        queue_cmd(CMD_FLOW, 1, 0, 0);
        queue_cmd(CMD_FLOW, 0, 1, 0);
        queue_cmd(CMD_ADD, 0, 2, 1);

        write_vcount(16);
        queue_random(700, 17);
        write_vcount(mflg_pkg::NUM_VTX);
        send_idle_pct = 53;
        queue_random(700, 24);
        // hold off until the graph work is finished, then shrink the range
        write_vcount(12);
        send_idle_pct = 0;
        queue_random(500, 13);
        write_vcount(2);
        queue_random(100, 3);

        drain();
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: results expected %0d actual 0",
                     $time, expected_results.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
